/* rtl/gbs_pkg.sv */
// Shared types, widths and constants of the greedy box suppression block.
// Holds the per-axis overlap function used by the sequencer datapath.
// Depends on nothing; every other file but gbs_checker refers to it by scoped names.
package gbs_pkg;

  localparam int MAX_BOXES_DEF = 256;

  localparam int COORD_W = 16;
  localparam int CLASS_W = 5;
  localparam int INDEX_W = 8;
  localparam int THR_W   = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd77;

  // Signed datapath widths
  localparam int OV_W   = COORD_W + 1;       // per-axis overlap and edge difference
  localparam int AREA_W = 2 * COORD_W + 1;   // area or intersection
  localparam int U_W    = AREA_W + 2;        // union
  localparam int MA_W   = U_W;               // multiplier operand a
  localparam int MB_W   = OV_W;              // multiplier operand b
  localparam int P_W    = MA_W + MB_W;       // multiplier product
  localparam int LHS_SH = 8;                 // intersection scaled by 256

  typedef struct packed {
    logic [COORD_W-1:0] y_max;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_min;
  } box_t;

  typedef struct packed {
    logic               first_in_set;
    logic [CLASS_W-1:0] class_id;
    logic [INDEX_W-1:0] box_index;
    box_t               box;
  } item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_id;
    logic [INDEX_W-1:0] box_index;
    logic               kept;
    logic               store_full;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_CHECK,
    ST_READ,
    ST_OVL,
    ST_MOV,
    ST_MAB,
    ST_SUM,
    ST_MTU,
    ST_CMP,
    ST_DONE
  } state_t;

  // Overlap on one axis; the pair with the smaller min goes first (a on a tie).
  // Negative for inverted edges, as in the signed float formula.
  function automatic logic signed [OV_W-1:0] axis_overlap(
    input logic [COORD_W-1:0] a0,
    input logic [COORD_W-1:0] a1,
    input logic [COORD_W-1:0] b0,
    input logic [COORD_W-1:0] b1
  );
    logic [COORD_W-1:0] lo0, hi0, lo1, hi1, hmin;
    logic signed [OV_W-1:0] res;
    begin
      lo0 = a0;
      hi0 = a1;
      lo1 = b0;
      hi1 = b1;
      if (a0 > b0) begin
        lo0 = b0;
        hi0 = b1;
        lo1 = a0;
        hi1 = a1;
      end
      hmin = (hi0 < hi1) ? hi0 : hi1;
      if (hi0 < lo1) begin
        res = '0;
      end else begin
        res = $signed({1'b0, hmin}) - $signed({1'b0, lo1});
      end
      return res;
    end
  endfunction

endpackage

/* rtl/gbs_mul.sv */
// Shared signed multiplier of the suppression sequencer, product registered.
// Uses widths from gbs_pkg.
module gbs_mul (
  input  logic                             clk,
  input  logic signed [gbs_pkg::MA_W-1:0]  a,
  input  logic signed [gbs_pkg::MB_W-1:0]  b,
  output logic signed [gbs_pkg::P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/gbs_store.sv */
// Kept-box store: one write port, one read port with registered read data.
// Entries past the fill count are never read, so the array has no reset.
// Uses box_t from gbs_pkg.
module gbs_store #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF,
  parameter int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  gbs_pkg::box_t       wdata,
  input  logic [IDX_W-1:0]    raddr,
  output gbs_pkg::box_t       rdata
);

  gbs_pkg::box_t mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gbs_engine.sv */
// Sequencer and datapath of greedy suppression: walks the kept boxes one by
// one through the shared multiplier and decides keep or suppress.
// Depends on gbs_pkg, gbs_mul and gbs_store.
module gbs_engine #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  gbs_pkg::item_t              item,
  input  logic [gbs_pkg::THR_W-1:0]   threshold,
  input  logic                        out_free,
  output logic                        ready,
  output logic                        done,
  output gbs_pkg::res_t               res
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  gbs_pkg::state_t state, state_next;

  gbs_pkg::item_t item_r;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] k;
  logic keep_r, full_r;

  logic signed [gbs_pkg::AREA_W-1:0] area_a, ov;
  logic signed [gbs_pkg::OV_W-1:0]   ox, oy, dxb, dyb;
  logic signed [gbs_pkg::U_W-1:0]    u;

  logic signed [gbs_pkg::MA_W-1:0] mul_a;
  logic signed [gbs_pkg::MB_W-1:0] mul_b;
  logic signed [gbs_pkg::P_W-1:0]  prod;

  gbs_pkg::box_t rdata;
  logic we;

  logic signed [gbs_pkg::OV_W-1:0] dxa, dya;
  logic signed [gbs_pkg::P_W-1:0]  lhs;
  logic store_full_now, last_box, pass;

  gbs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  gbs_store #(
    .MAX_BOXES (MAX_BOXES),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (item_r.box),
    .raddr (k),
    .rdata (rdata)
  );

  assign dxa = $signed({1'b0, item_r.box.x_max}) - $signed({1'b0, item_r.box.x_min});
  assign dya = $signed({1'b0, item_r.box.y_max}) - $signed({1'b0, item_r.box.y_min});

  assign store_full_now = (count == CNT_W'(MAX_BOXES));
  assign last_box       = ((CNT_W'(k) + CNT_W'(1)) == count);

  // Test on the registered product T*u against intersection*256
  assign lhs = {{(gbs_pkg::P_W - gbs_pkg::AREA_W - gbs_pkg::LHS_SH){ov[gbs_pkg::AREA_W-1]}},
                ov, {gbs_pkg::LHS_SH{1'b0}}};
  always_comb begin
    if (u == '0) begin
      pass = 1'b1;
    end else if (!u[gbs_pkg::U_W-1]) begin
      pass = (lhs <= prod);
    end else begin
      pass = (lhs >= prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gbs_pkg::ST_IDLE:  if (start) state_next = gbs_pkg::ST_AREA;
      gbs_pkg::ST_AREA:  state_next = gbs_pkg::ST_CHECK;
      gbs_pkg::ST_CHECK: begin
        if (store_full_now || count == '0) state_next = gbs_pkg::ST_DONE;
        else state_next = gbs_pkg::ST_READ;
      end
      gbs_pkg::ST_READ:  state_next = gbs_pkg::ST_OVL;
      gbs_pkg::ST_OVL:   state_next = gbs_pkg::ST_MOV;
      gbs_pkg::ST_MOV:   state_next = gbs_pkg::ST_MAB;
      gbs_pkg::ST_MAB:   state_next = gbs_pkg::ST_SUM;
      gbs_pkg::ST_SUM:   state_next = gbs_pkg::ST_MTU;
      gbs_pkg::ST_MTU:   state_next = gbs_pkg::ST_CMP;
      gbs_pkg::ST_CMP: begin
        if (!pass || last_box) state_next = gbs_pkg::ST_DONE;
        else state_next = gbs_pkg::ST_READ;
      end
      gbs_pkg::ST_DONE:  if (out_free) state_next = gbs_pkg::ST_IDLE;
      default:           state_next = gbs_pkg::ST_IDLE;
    endcase
  end

  // Operand select of the shared multiplier and handshake outputs
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ready = 1'b0;
    done  = 1'b0;
    unique case (state)
      gbs_pkg::ST_IDLE: ready = 1'b1;
      gbs_pkg::ST_AREA: begin
        mul_a = gbs_pkg::MA_W'(dxa);
        mul_b = dya;
      end
      gbs_pkg::ST_MOV: begin
        mul_a = gbs_pkg::MA_W'(ox);
        mul_b = oy;
      end
      gbs_pkg::ST_MAB: begin
        mul_a = gbs_pkg::MA_W'(dxb);
        mul_b = dyb;
      end
      gbs_pkg::ST_MTU: begin
        mul_a = u;
        mul_b = $signed({{(gbs_pkg::MB_W - gbs_pkg::THR_W){1'b0}}, threshold});
      end
      gbs_pkg::ST_DONE: done = out_free;
      default: ;
    endcase
  end

  assign we = done && keep_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (state == gbs_pkg::ST_IDLE && start && item.first_in_set) begin
        count <= '0;
      end else if (we) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gbs_pkg::ST_IDLE: if (start) item_r <= item;
      gbs_pkg::ST_CHECK: begin
        area_a <= prod[gbs_pkg::AREA_W-1:0];
        k      <= '0;
        full_r <= store_full_now;
        keep_r <= !store_full_now;
      end
      gbs_pkg::ST_OVL: begin
        ox  <= gbs_pkg::axis_overlap(item_r.box.x_min, item_r.box.x_max,
                                     rdata.x_min, rdata.x_max);
        oy  <= gbs_pkg::axis_overlap(item_r.box.y_min, item_r.box.y_max,
                                     rdata.y_min, rdata.y_max);
        dxb <= $signed({1'b0, rdata.x_max}) - $signed({1'b0, rdata.x_min});
        dyb <= $signed({1'b0, rdata.y_max}) - $signed({1'b0, rdata.y_min});
      end
      gbs_pkg::ST_MAB: ov <= prod[gbs_pkg::AREA_W-1:0];
      gbs_pkg::ST_SUM: begin
        // Kept area may be negative for an inverted box: sign-extend it
        u <= gbs_pkg::U_W'(area_a)
             + gbs_pkg::U_W'($signed(prod[gbs_pkg::AREA_W-1:0]))
             - gbs_pkg::U_W'(ov);
      end
      gbs_pkg::ST_CMP: begin
        if (!pass) keep_r <= 1'b0;
        k <= k + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign res.class_id   = item_r.class_id;
  assign res.box_index  = item_r.box_index;
  assign res.kept       = keep_r;
  assign res.store_full = full_r;

endmodule

/* rtl/greedy_box_suppression_top.sv */
// Greedy box suppression, top level: stream ports, threshold register and
// result register around the suppression engine.
// Depends on gbs_pkg and gbs_engine.
//
// Usage:
//   s_axis carries one candidate box per request, sorted by descending score
//   within a set; tuser[0] = first_in_set empties the kept list first.
//   m_axis returns one verdict per box: class, index, kept and store_full.
//   cfg writes the 9-bit IoU threshold (units of 1/256); write it only while
//   no box is in flight. cfg_ready is always high.
// Operation:
//   A box is checked against the kept boxes in store order, one at a time,
//   through a single shared multiplier (own area, intersection, kept area,
//   threshold times union) and stops at the first overlap above the threshold.
//   The result appears as the engine returns to idle, and s_axis_tready rises
//   with it; the next box may be taken in that same cycle at the earliest,
//   but the engine takes no new box while it is busy with the last one.
// Reset and stall:
//   rst (synchronous) empties the kept list and loads threshold 77. A result
//   waits in the output register; the next box is still accepted, but its
//   verdict is held in the engine until the receiver takes the previous one.
module greedy_box_suppression_top #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // class_id[4:0], box_index[12:5], x_min[28:13], y_min[44:29],
  // x_max[60:45], y_max[76:61], zero [79:77]
  input  logic [79:0]                s_axis_tdata,
  // first_in_set[0]
  input  logic [0:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // class_id_out[4:0], box_index_out[12:5], zero [15:13]
  output logic [15:0]                m_axis_tdata,
  // kept[0], store_full[1]
  output logic [1:0]                 m_axis_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gbs_pkg::THR_W-1:0]  cfg_data
);

  logic [gbs_pkg::THR_W-1:0] threshold;
  gbs_pkg::item_t item;
  gbs_pkg::res_t  res, res_r;
  logic start, done, out_free, eng_ready;

  // Unpack the request payload
  assign item.first_in_set  = s_axis_tuser[0];
  assign item.class_id      = s_axis_tdata[4:0];
  assign item.box_index     = s_axis_tdata[12:5];
  assign item.box.x_min     = s_axis_tdata[28:13];
  assign item.box.y_min     = s_axis_tdata[44:29];
  assign item.box.x_max     = s_axis_tdata[60:45];
  assign item.box.y_max     = s_axis_tdata[76:61];

  assign s_axis_tready = eng_ready;
  assign start         = s_axis_tvalid && eng_ready;

  // Threshold register, always ready; the sender must write it only while idle, which the block leaves unchecked
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbs_pkg::THR_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  gbs_engine #(
    .MAX_BOXES (MAX_BOXES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .threshold (threshold),
    .out_free  (out_free),
    .ready     (eng_ready),
    .done      (done),
    .res       (res)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign m_axis_tdata = {3'b000, res_r.box_index, res_r.class_id};
  assign m_axis_tuser = {res_r.store_full, res_r.kept};

endmodule

/* rtl/gbs_checker.sv */
// Port-level checks of the greedy box suppression top level, with its bind.
// Depends only on the top level's ports.
module gbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // The engine is busy in the cycle after taking a box
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready right after a request was accepted");

  // A new verdict appears only as the engine goes back to idle
  a_result_returns_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while engine not idle");

  // A box rejected for a full store is never also marked kept
  a_full_not_kept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both kept and store_full");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
